[sv/ilst_pkg.sv]
// shared widths and codes for the indexed ordered list
package ilst_pkg;

  localparam int MODE_W = 3;
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_BACK  = 3'd3,
    MODE_CLEAR     = 3'd4,
    MODE_READ      = 3'd5
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

endpackage

[sv/ilst_if.sv]
// request and result channel interfaces
interface ilst_in_if;
  logic                                valid;
  logic                                ready;
  logic        [ilst_pkg::MODE_W-1:0]  mode;
  logic        [ilst_pkg::POS_W-1:0]   position;
  logic signed [ilst_pkg::WORD_W-1:0]  value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface ilst_out_if;
  logic                                valid;
  logic                                ready;
  logic        [ilst_pkg::STAT_W-1:0]  status;
  logic signed [ilst_pkg::WORD_W-1:0]  read_value;
  logic        [ilst_pkg::LEN_W-1:0]   length;

  modport source (output valid, output status, output read_value, output length, input ready);
  modport sink   (input valid, input status, input read_value, input length, output ready);
endinterface

[sv/indexed_ordered_list.sv]
// indexed ordered list: sequencer that shifts stored words through the word store
// clear, refused requests and unused modes go straight to the result state
// read waits on the registered read port; insert then fills the new word
// each moved word is read in S_SH_RD and written in S_SH_WR on the word store
// one transaction at a time; a finished result may wait while the next is accepted
// synchronous active-low reset empties the list; stored words are not cleared
module indexed_ordered_list #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  ilst_in_if.sink     in_ch,
  ilst_out_if.source  out_ch
);
  import ilst_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int CW = (OW > POS_W) ? OW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_FILL,
    S_RD_WAIT,
    S_DONE
  } state_t;

  state_t                   state_r;
  logic        [OW-1:0]     occ_r;
  logic        [AW-1:0]     k_r;
  logic        [AW-1:0]     tgt_r;
  logic                     ins_r;
  logic signed [WORD_W-1:0] word_r;
  logic signed [WORD_W-1:0] rd_r;
  status_t                  status_r;
  logic                     out_valid_r;
  status_t                  out_status_r;
  logic signed [WORD_W-1:0] out_rd_r;
  logic        [LEN_W-1:0]  out_len_r;

  logic                     accept;
  mode_t                    mode;
  logic        [CW-1:0]     pos_x;
  logic        [CW-1:0]     occ_x;
  logic        [CW-1:0]     cap_x;
  logic        [CW-1:0]     ins_pos_x;
  logic        [CW-1:0]     del_pos_x;
  logic                     mem_we;
  logic        [AW-1:0]     mem_waddr;
  logic signed [WORD_W-1:0] mem_wdata;
  logic        [AW-1:0]     mem_raddr;
  logic signed [WORD_W-1:0] mem_rdata;

  assign accept    = in_ch.valid && in_ch.ready;
  assign mode      = mode_t'(in_ch.mode);
  assign pos_x     = CW'(in_ch.position);
  assign occ_x     = CW'(occ_r);
  assign cap_x     = CW'(CAPACITY);
  assign ins_pos_x = (mode == MODE_INS_FRONT) ? pos_x : occ_x - pos_x;
  assign del_pos_x = (mode == MODE_DEL_FRONT) ? pos_x : occ_x - CW'(1) - pos_x;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.length     = out_len_r;

  always_comb begin
    mem_we    = (state_r == S_SH_WR) || (state_r == S_FILL);
    mem_waddr = (state_r == S_FILL) ? tgt_r : k_r;
    mem_wdata = (state_r == S_FILL) ? word_r : mem_rdata;
    if (state_r == S_SH_RD) begin
      mem_raddr = ins_r ? k_r - AW'(1) : k_r + AW'(1);
    end else begin
      mem_raddr = pos_x[AW-1:0];
    end
  end

  ilst_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            word_r   <= in_ch.value;
            rd_r     <= '0;
            status_r <= ST_OK;
            state_r  <= S_DONE;
            unique case (mode)
              MODE_INS_FRONT, MODE_INS_BACK: begin
                if (occ_x == cap_x) begin
                  status_r <= ST_FULL;
                end else if (pos_x > occ_x) begin
                  status_r <= ST_BADIDX;
                end else begin
                  ins_r   <= 1'b1;
                  tgt_r   <= ins_pos_x[AW-1:0];
                  k_r     <= occ_r[AW-1:0];
                  state_r <= (occ_x > ins_pos_x) ? S_SH_RD : S_FILL;
                end
              end
              MODE_DEL_FRONT, MODE_DEL_BACK: begin
                if (occ_r == '0) begin
                  status_r <= ST_EMPTY;
                end else if (pos_x >= occ_x) begin
                  status_r <= ST_BADIDX;
                end else begin
                  ins_r <= 1'b0;
                  k_r   <= del_pos_x[AW-1:0];
                  if (del_pos_x + CW'(1) < occ_x) begin
                    state_r <= S_SH_RD;
                  end else begin
                    occ_r <= occ_r - OW'(1);
                  end
                end
              end
              MODE_CLEAR: begin
                occ_r <= '0;
              end
              MODE_READ: begin
                if (pos_x >= occ_x) begin
                  status_r <= ST_BADIDX;
                end else begin
                  state_r <= S_RD_WAIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SH_RD: begin
          state_r <= S_SH_WR;
        end
        S_SH_WR: begin
          if (ins_r) begin
            k_r     <= k_r - AW'(1);
            state_r <= (CW'(k_r) > CW'(tgt_r) + CW'(1)) ? S_SH_RD : S_FILL;
          end else begin
            k_r <= k_r + AW'(1);
            if (CW'(k_r) + CW'(2) < occ_x) begin
              state_r <= S_SH_RD;
            end else begin
              occ_r   <= occ_r - OW'(1);
              state_r <= S_DONE;
            end
          end
        end
        S_FILL: begin
          occ_r   <= occ_r + OW'(1);
          state_r <= S_DONE;
        end
        S_RD_WAIT: begin
          rd_r    <= mem_rdata;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_rd_r     <= rd_r;
            out_len_r    <= LEN_W'(occ_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/ilst_mem.sv]
// word store with one write port and one registered read port
module ilst_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic        [AW-1:0]                waddr,
  input  logic signed [ilst_pkg::WORD_W-1:0]  wdata,
  input  logic        [AW-1:0]                raddr,
  output logic signed [ilst_pkg::WORD_W-1:0]  rdata
);
  import ilst_pkg::*;

  logic signed [WORD_W-1:0] mem_r [DEPTH];
  logic signed [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
